// ===== hw/rtl/idet_pkg.sv =====
// idet_pkg: widths, handshake structs, permutation table and state type for the
// integer matrix determinant block. Used by every module under hw/rtl.
`timescale 1ns / 1ps

package idet_pkg;

    localparam int MAX_SIZE   = 4;
    localparam int ENTRY_W    = 16;
    localparam int SIZE_W     = 3;
    localparam int IDX_W      = $clog2(MAX_SIZE);
    localparam int DET_W      = 64;
    localparam int PAIR_W     = 2 * ENTRY_W;
    localparam int PROD_W     = 2 * PAIR_W;
    localparam int ACC_W      = 68;
    localparam int NUM_TERMS  = 24;
    localparam int TERM_W     = $clog2(NUM_TERMS);
    localparam int BANKS      = 2;
    localparam int BANK_W     = $clog2(BANKS);
    localparam int JOBQ_DEPTH = BANKS;
    localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_MATRIX_SIZE = 1'b0;

    localparam logic signed [DET_W-1:0] DET_MAX = {1'b0, {(DET_W-1){1'b1}}};
    localparam logic signed [DET_W-1:0] DET_MIN = {1'b1, {(DET_W-1){1'b0}}};

    // column picked by each row, row 0 in the top two bits
    localparam logic [MAX_SIZE*IDX_W-1:0] PERM_TABLE [NUM_TERMS] = '{
        8'b00_01_10_11, 8'b00_01_11_10, 8'b00_10_01_11, 8'b00_10_11_01,
        8'b00_11_01_10, 8'b00_11_10_01, 8'b01_00_10_11, 8'b01_00_11_10,
        8'b01_10_00_11, 8'b01_10_11_00, 8'b01_11_00_10, 8'b01_11_10_00,
        8'b10_00_01_11, 8'b10_00_11_01, 8'b10_01_00_11, 8'b10_01_11_00,
        8'b10_11_00_01, 8'b10_11_01_00, 8'b11_00_01_10, 8'b11_00_10_01,
        8'b11_01_00_10, 8'b11_01_10_00, 8'b11_10_00_01, 8'b11_10_01_00
    };

    // odd permutation flags, bit k for term k
    localparam logic [NUM_TERMS-1:0] PERM_ODD = 24'b0110_0110_0110_0110_0110_0110;

    typedef struct packed {
        logic                      en;
        logic [BANK_W-1:0]         bank;
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic signed [ENTRY_W-1:0] data;
    } store_wr_t;

    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic [SIZE_W-1:0] size;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DRAIN,
        BK_DONE
    } back_state_t;

    function automatic logic [IDX_W-1:0] perm_col(input logic [TERM_W-1:0] k, input int r);
        logic [MAX_SIZE*IDX_W-1:0] p;
        p = PERM_TABLE[k];
        return p[(MAX_SIZE-1-r)*IDX_W +: IDX_W];
    endfunction

    function automatic logic perm_odd(input logic [TERM_W-1:0] k);
        return PERM_ODD[k];
    endfunction

endpackage

// ===== hw/rtl/integer_matrix_determinant.sv =====
// integer_matrix_determinant: top level with the size register on the APB port,
// front loader, job queue and term engine. Depends on idet_pkg and its modules.
//
//   channel  | signals                                   | carries
//   ---------+-------------------------------------------+---------------------------
//   input    | in_valid, in_ready, entry_value           | one matrix entry, row-major
//   output   | out_valid, out_ready, det_value, det_sat. | determinant of one matrix
//   config   | psel, penable, pwrite, paddr, pwdata, ... | matrix_size at address 0
//
// entries load one per cycle into one of two banks while the other is evaluated
// the term engine sums all 24 signed 4x4 permutation products (smaller sizes are
// padded with identity), one term issued per cycle
// in_ready drops with both banks full
// out_ready low holds the result word; the engine waits only at its final write-back
// reset clears control state and sets matrix_size to 4
`timescale 1ns / 1ps

module integer_matrix_determinant (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [idet_pkg::ENTRY_W-1:0]   entry_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [idet_pkg::DET_W-1:0]     det_value,
    output logic                                  det_saturated,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [idet_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [idet_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [idet_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);

    logic [idet_pkg::SIZE_W-1:0] size_reg, size_next;
    logic [idet_pkg::SIZE_W-1:0] eff_size;
    logic                        reg_sel;
    logic                        size_wr;

    logic                q_full;
    logic                push;
    idet_pkg::job_t      push_job;
    idet_pkg::store_wr_t store_wr;
    logic                pop;
    logic                head_valid;
    idet_pkg::job_t      head_job;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[idet_pkg::APB_ADDR_W-1] == idet_pkg::REG_MATRIX_SIZE);
    assign size_wr = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? idet_pkg::APB_DATA_W'(size_reg) : '0;

    always_comb
    begin
        size_next = size_reg;
        if (size_wr)
            size_next = pwdata[idet_pkg::SIZE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= idet_pkg::SIZE_W'(idet_pkg::MAX_SIZE);
        else
            size_reg <= size_next;
    end

    always_comb
    begin
        if (size_reg == '0)
            eff_size = idet_pkg::SIZE_W'(1);
        else if (size_reg > idet_pkg::SIZE_W'(idet_pkg::MAX_SIZE))
            eff_size = idet_pkg::SIZE_W'(idet_pkg::MAX_SIZE);
        else
            eff_size = size_reg;
    end

    idet_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .entry_value (entry_value),
        .eff_size    (eff_size),
        .load_clear  (size_wr),
        .q_full      (q_full),
        .push        (push),
        .push_job    (push_job),
        .store_wr    (store_wr)
    );

    idet_jobq u_jobq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    idet_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .store_wr      (store_wr),
        .head_valid    (head_valid),
        .head_job      (head_job),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .det_value     (det_value),
        .det_saturated (det_saturated)
    );

endmodule

// ===== hw/rtl/idet_front.sv =====
// idet_front: accepts entry words, tracks row and column, writes the matrix
// bank and hands a job to the queue with the last entry. Depends on idet_pkg.
`timescale 1ns / 1ps

module idet_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [idet_pkg::ENTRY_W-1:0] entry_value,
    input  logic [idet_pkg::SIZE_W-1:0]        eff_size,
    input  logic                               load_clear,
    input  logic                               q_full,
    output logic                               push,
    output idet_pkg::job_t                     push_job,
    output idet_pkg::store_wr_t                store_wr
);

    logic [idet_pkg::IDX_W-1:0]  row_reg, row_next;
    logic [idet_pkg::IDX_W-1:0]  col_reg, col_next;
    logic [idet_pkg::BANK_W-1:0] bank_reg, bank_next;
    logic [idet_pkg::IDX_W-1:0]  last_idx;
    logic                        accept;
    logic                        last_row;
    logic                        last_col;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign last_idx = idet_pkg::IDX_W'(eff_size - idet_pkg::SIZE_W'(1));
    assign last_row = (row_reg == last_idx);
    assign last_col = (col_reg == last_idx);

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        bank_next = bank_reg;
        if (load_clear)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                if (last_row)
                begin
                    row_next  = '0;
                    bank_next = bank_reg + idet_pkg::BANK_W'(1);
                end
                else
                begin
                    row_next = row_reg + idet_pkg::IDX_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + idet_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            bank_reg <= '0;
        end
        else
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            bank_reg <= bank_next;
        end
    end

    assign push          = accept && last_row && last_col;
    assign push_job.bank = bank_reg;
    assign push_job.size = eff_size;

    assign store_wr.en   = accept;
    assign store_wr.bank = bank_reg;
    assign store_wr.row  = row_reg;
    assign store_wr.col  = col_reg;
    assign store_wr.data = entry_value;

endmodule

// ===== hw/rtl/idet_jobq.sv =====
// idet_jobq: short queue of loaded-matrix jobs between front and back;
// full means every bank holds a matrix. Depends on idet_pkg.
`timescale 1ns / 1ps

module idet_jobq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  idet_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output idet_pkg::job_t head_job
);

    idet_pkg::job_t job_mem [idet_pkg::JOBQ_DEPTH];

    logic [idet_pkg::JOBQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [idet_pkg::JOBQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [idet_pkg::JOBQ_CNT_W-1:0] count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full       = (count_reg == idet_pkg::JOBQ_CNT_W'(idet_pkg::JOBQ_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = job_mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == idet_pkg::JOBQ_PTR_W'(idet_pkg::JOBQ_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + idet_pkg::JOBQ_PTR_W'(1);
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == idet_pkg::JOBQ_PTR_W'(idet_pkg::JOBQ_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + idet_pkg::JOBQ_PTR_W'(1);
        end
        if (do_push && !do_pop)
            count_next = count_reg + idet_pkg::JOBQ_CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - idet_pkg::JOBQ_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            job_mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/idet_back.sv =====
// idet_back: matrix banks and the permutation-term engine: read, pair multiply,
// product, accumulate, saturate into the output register. Depends on idet_pkg.
`timescale 1ns / 1ps

module idet_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  idet_pkg::store_wr_t              store_wr,
    input  logic                             head_valid,
    input  idet_pkg::job_t                   head_job,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [idet_pkg::DET_W-1:0] det_value,
    output logic                             det_saturated
);

    logic signed [idet_pkg::ENTRY_W-1:0]
        store_mem [idet_pkg::BANKS][idet_pkg::MAX_SIZE][idet_pkg::MAX_SIZE];

    idet_pkg::back_state_t state_reg, state_next;

    logic [idet_pkg::TERM_W-1:0] term_reg, term_next;
    logic                        start;
    logic                        issue;
    logic                        last_term;
    logic                        load_out;

    logic [idet_pkg::IDX_W-1:0]          rd_col  [idet_pkg::MAX_SIZE];
    logic signed [idet_pkg::ENTRY_W-1:0] rd_next [idet_pkg::MAX_SIZE];
    logic signed [idet_pkg::ENTRY_W-1:0] rd_reg  [idet_pkg::MAX_SIZE];

    logic                               va_reg, vb_reg, vc_reg;
    logic                               odd_a_reg, odd_b_reg, odd_c_reg;
    logic signed [idet_pkg::PAIR_W-1:0] p01_reg, p23_reg;
    logic signed [idet_pkg::PROD_W-1:0] prod_reg;
    logic signed [idet_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic signed [idet_pkg::ACC_W-1:0]  term_ext;

    logic                               out_valid_reg, out_valid_next;
    logic signed [idet_pkg::DET_W-1:0]  det_value_reg;
    logic                               det_sat_reg;
    logic [idet_pkg::ACC_W-idet_pkg::DET_W:0] acc_top;
    logic                               fits;

    // matrix banks
    always_ff @(posedge clk)
    begin
        if (store_wr.en)
            store_mem[store_wr.bank][store_wr.row][store_wr.col] <= store_wr.data;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            idet_pkg::BK_IDLE:
            begin
                if (head_valid)
                    state_next = idet_pkg::BK_RUN;
            end
            idet_pkg::BK_RUN:
            begin
                if (last_term)
                    state_next = idet_pkg::BK_DRAIN;
            end
            idet_pkg::BK_DRAIN:
            begin
                if (!(va_reg || vb_reg || vc_reg))
                    state_next = idet_pkg::BK_DONE;
            end
            idet_pkg::BK_DONE:
            begin
                if (load_out)
                    state_next = idet_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = idet_pkg::BK_IDLE;
            end
        endcase
    end

    assign last_term = (term_reg == idet_pkg::TERM_W'(idet_pkg::NUM_TERMS - 1));

    always_comb
    begin
        start    = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            idet_pkg::BK_IDLE:
            begin
                start = head_valid;
            end
            idet_pkg::BK_RUN:
            begin
                issue = 1'b1;
            end
            idet_pkg::BK_DONE:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                start = 1'b0;
            end
        endcase
    end

    assign pop = issue && last_term;

    always_comb
    begin
        term_next = term_reg;
        if (start || pop)
            term_next = '0;
        else if (issue)
            term_next = term_reg + idet_pkg::TERM_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= idet_pkg::BK_IDLE;
            term_reg  <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
            vc_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            va_reg    <= issue;
            vb_reg    <= va_reg;
            vc_reg    <= vb_reg;
        end
    end

    // entry read, identity outside the loaded size
    always_comb
    begin
        for (int r = 0; r < idet_pkg::MAX_SIZE; r++)
        begin
            rd_col[r] = idet_pkg::perm_col(term_reg, r);
            if ((idet_pkg::SIZE_W'(r) >= head_job.size) ||
                (idet_pkg::SIZE_W'(rd_col[r]) >= head_job.size))
            begin
                if (rd_col[r] == idet_pkg::IDX_W'(r))
                    rd_next[r] = idet_pkg::ENTRY_W'(1);
                else
                    rd_next[r] = '0;
            end
            else
            begin
                rd_next[r] = store_mem[head_job.bank][idet_pkg::IDX_W'(r)][rd_col[r]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            for (int r = 0; r < idet_pkg::MAX_SIZE; r++)
                rd_reg[r] <= rd_next[r];
            odd_a_reg <= idet_pkg::perm_odd(term_reg);
        end
        p01_reg   <= idet_pkg::PAIR_W'(rd_reg[0]) * idet_pkg::PAIR_W'(rd_reg[1]);
        p23_reg   <= idet_pkg::PAIR_W'(rd_reg[2]) * idet_pkg::PAIR_W'(rd_reg[3]);
        odd_b_reg <= odd_a_reg;
        prod_reg  <= idet_pkg::PROD_W'(p01_reg) * idet_pkg::PROD_W'(p23_reg);
        odd_c_reg <= odd_b_reg;
    end

    // signed accumulate
    assign term_ext = idet_pkg::ACC_W'(prod_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (start)
            acc_next = '0;
        else if (vc_reg)
        begin
            if (odd_c_reg)
                acc_next = acc_reg - term_ext;
            else
                acc_next = acc_reg + term_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // saturation and output register
    assign acc_top = acc_reg[idet_pkg::ACC_W-1:idet_pkg::DET_W-1];
    assign fits    = (&acc_top) || !(|acc_top);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            det_sat_reg <= !fits;
            if (fits)
                det_value_reg <= acc_reg[idet_pkg::DET_W-1:0];
            else if (acc_reg[idet_pkg::ACC_W-1])
                det_value_reg <= idet_pkg::DET_MIN;
            else
                det_value_reg <= idet_pkg::DET_MAX;
        end
    end

    assign out_valid     = out_valid_reg;
    assign det_value     = det_value_reg;
    assign det_saturated = det_sat_reg;

endmodule

// ===== dv/integer_matrix_determinant_tb.sv =====
// integer_matrix_determinant_tb: self-checking bench for the integer matrix determinant
// block, with a Leibniz-sum predictor, random idling and APB size writes.
// Depends on idet_pkg and the integer_matrix_determinant top level.
`timescale 1ns / 1ps

module integer_matrix_determinant_tb;

    localparam int ITEMS_TOTAL  = 1450;
    localparam int QUIET_TAIL   = 150;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 2000000;

    localparam logic [idet_pkg::APB_ADDR_W-1:0] ADDR_MATRIX_SIZE =
        idet_pkg::APB_ADDR_W'(4 * idet_pkg::REG_MATRIX_SIZE);
    localparam logic [idet_pkg::APB_ADDR_W-1:0] ADDR_NO_REG =
        ADDR_MATRIX_SIZE + idet_pkg::APB_ADDR_W'(4);
    localparam logic [idet_pkg::SIZE_W-1:0] SIZE_AT_RESET = idet_pkg::SIZE_W'(4);

    localparam logic signed [idet_pkg::ENTRY_W-1:0] ENTRY_MIN =
        {1'b1, {(idet_pkg::ENTRY_W-1){1'b0}}};
    localparam logic signed [idet_pkg::ENTRY_W-1:0] ENTRY_MAX =
        {1'b0, {(idet_pkg::ENTRY_W-1){1'b1}}};

    typedef enum int {
        FILL_UNIFORM,
        FILL_SMALL,
        FILL_EXTREME,
        FILL_HADAMARD
    } fill_mode_t;

    typedef struct packed {
        logic signed [idet_pkg::DET_W-1:0] value;
        logic                              saturated;
    } det_result_t;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   in_valid;
    logic                                   in_ready;
    logic signed [idet_pkg::ENTRY_W-1:0]    entry_value;
    logic                                   out_valid;
    logic                                   out_ready = 1'b0;
    logic signed [idet_pkg::DET_W-1:0]      det_value;
    logic                                   det_saturated;
    logic                                   psel;
    logic                                   penable;
    logic                                   pwrite;
    logic [idet_pkg::APB_ADDR_W-1:0]        paddr;
    logic [idet_pkg::APB_DATA_W-1:0]        pwdata;
    logic [idet_pkg::APB_DATA_W-1:0]        prdata;
    logic                                   pready;

    det_result_t                         det_expected [$];
    logic signed [idet_pkg::ENTRY_W-1:0] matrix_entries [idet_pkg::MAX_SIZE*idet_pkg::MAX_SIZE];
    logic [idet_pkg::SIZE_W-1:0]         size_reg = SIZE_AT_RESET;
    int                                  loaded_count = 0;
    int                                  items_sent = 0;
    int                                  errors = 0;
    int                                  cycle_count = 0;
    int                                  stall_left = 0;
    bit                                  idle_on = 1'b1;

    integer_matrix_determinant dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .entry_value   (entry_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .det_value     (det_value),
        .det_saturated (det_saturated),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic int active_size(input logic [idet_pkg::SIZE_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > idet_pkg::MAX_SIZE)
            return idet_pkg::MAX_SIZE;
        return int'(raw);
    endfunction

    // exact sum over all permutations, then clamp to the signed 64-bit range
    function automatic det_result_t predict_det(input int n);
        logic signed [127:0] acc;
        logic signed [127:0] prod;
        int                  digit [idet_pkg::MAX_SIZE];
        int                  code_max;
        int                  code;
        int                  rest;
        int                  r;
        int                  s;
        int                  inversions;
        bit                  distinct;
        det_result_t         res;
        code_max = 1;
        for (r = 0; r < n; r++)
            code_max = code_max * n;
        acc = '0;
        for (code = 0; code < code_max; code++)
        begin
            rest = code;
            for (r = 0; r < n; r++)
            begin
                digit[r] = rest % n;
                rest = rest / n;
            end
            distinct = 1'b1;
            inversions = 0;
            for (r = 0; r < n; r++)
                for (s = r + 1; s < n; s++)
                begin
                    if (digit[r] == digit[s])
                        distinct = 1'b0;
                    else if (digit[r] > digit[s])
                        inversions++;
                end
            if (distinct)
            begin
                prod = 128'sd1;
                for (r = 0; r < n; r++)
                    prod = prod * matrix_entries[r*n + digit[r]];
                acc = inversions[0] ? acc - prod : acc + prod;
            end
        end
        if (acc[127:63] == {65{1'b0}} || acc[127:63] == {65{1'b1}})
        begin
            res.value = acc[idet_pkg::DET_W-1:0];
            res.saturated = 1'b0;
        end
        else
        begin
            res.value = acc[127] ? idet_pkg::DET_MIN : idet_pkg::DET_MAX;
            res.saturated = 1'b1;
        end
        return res;
    endfunction

    // result side: random stall bursts on out_ready
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 11);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        det_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (det_expected.size() == 0)
            begin
                $error("det_value word with nothing expected, actual %0d", det_value);
                errors++;
            end
            else
            begin
                want = det_expected.pop_front();
                if (det_value !== want.value)
                begin
                    $error("det_value expected %0d actual %0d", want.value, det_value);
                    errors++;
                end
                if (det_saturated !== want.saturated)
                begin
                    $error("det_saturated expected %0d actual %0d", want.saturated,
                           det_saturated);
                    errors++;
                end
            end
        end
    end

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (det_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [idet_pkg::APB_ADDR_W-1:0] addr,
                             input logic [idet_pkg::APB_DATA_W-1:0] data);
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_MATRIX_SIZE)
        begin
            size_reg = data[idet_pkg::SIZE_W-1:0];
            loaded_count = 0;
        end
        @(posedge clk);
    endtask

    task automatic check_size_reg();
        logic [idet_pkg::APB_DATA_W-1:0] word;
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_MATRIX_SIZE;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        word = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (word !== idet_pkg::APB_DATA_W'(size_reg))
        begin
            $error("matrix_size expected %0d actual %0d", size_reg, word);
            errors++;
        end
        @(posedge clk);
    endtask

    task automatic send_entry(input logic signed [idet_pkg::ENTRY_W-1:0] v);
        int gap;
        int n;
        if (items_sent >= ITEMS_TOTAL - QUIET_TAIL)
            idle_on = 1'b0;
        gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        entry_value <= v;
        do @(posedge clk); while (!in_ready);
        n = active_size(size_reg);
        matrix_entries[loaded_count] = v;
        loaded_count++;
        items_sent++;
        if (loaded_count == n * n)
        begin
            det_expected.insert(det_expected.size(), predict_det(n));
            loaded_count = 0;
        end
    endtask

    task automatic load_entries(input int count, input int n, input fill_mode_t mode,
                                input logic [3:0] rflip, input logic [3:0] cflip);
        logic signed [idet_pkg::ENTRY_W-1:0] v;
        int i;
        int r;
        int c;
        for (i = 0; i < count; i++)
        begin
            r = i / n;
            c = i % n;
            case (mode)
                FILL_UNIFORM:
                    v = idet_pkg::ENTRY_W'($urandom);
                FILL_SMALL:
                    v = idet_pkg::ENTRY_W'(int'($urandom_range(0, 16)) - 8);
                FILL_EXTREME:
                    case ($urandom_range(0, 4))
                        0: v = ENTRY_MIN;
                        1: v = ENTRY_MAX;
                        2: v = '0;
                        3: v = idet_pkg::ENTRY_W'(-1);
                        default: v = idet_pkg::ENTRY_W'(1);
                    endcase
                default:
                    // scaled hadamard pattern, row and column flips set the sign
                    v = (^(r[1:0] & c[1:0]) ^ rflip[r] ^ cflip[c]) ? ENTRY_MIN : ENTRY_MAX;
            endcase
            send_entry(v);
        end
    endtask

    task automatic test_reset_size_saturation();
        check_size_reg();
        load_entries(idet_pkg::MAX_SIZE * idet_pkg::MAX_SIZE, idet_pkg::MAX_SIZE,
                     FILL_HADAMARD, 4'b0000, 4'b0000);
    endtask

    task automatic test_single_entry_extremes();
        write_reg(ADDR_MATRIX_SIZE, idet_pkg::APB_DATA_W'(1));
        send_entry(ENTRY_MIN);
        send_entry(ENTRY_MAX);
        send_entry('0);
        send_entry(idet_pkg::ENTRY_W'(1));
        // size zero behaves as one
        write_reg(ADDR_MATRIX_SIZE, idet_pkg::APB_DATA_W'(0));
        check_size_reg();
        send_entry(idet_pkg::ENTRY_W'(-1));
    endtask

    task automatic test_ignored_address();
        write_reg(ADDR_NO_REG, idet_pkg::APB_DATA_W'(3));
        check_size_reg();
        send_entry(ENTRY_MAX);
    endtask

    task automatic test_size_write_mid_load();
        write_reg(ADDR_MATRIX_SIZE, idet_pkg::APB_DATA_W'(3));
        send_entry(ENTRY_MAX);
        send_entry(ENTRY_MIN);
        write_reg(ADDR_MATRIX_SIZE, idet_pkg::APB_DATA_W'(2));
        send_entry(ENTRY_MIN);
        send_entry(ENTRY_MAX);
        send_entry(ENTRY_MAX);
        send_entry(ENTRY_MIN);
    endtask

    task automatic test_random_matrices();
        logic [idet_pkg::APB_DATA_W-1:0] cfg_word;
        logic [3:0]                      rflip;
        logic [3:0]                      cflip;
        fill_mode_t                      mode;
        int                              n;
        int                              matrices;
        int                              m;
        while (items_sent < ITEMS_TOTAL)
        begin
            idle_on = (items_sent < ITEMS_TOTAL - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0)
            begin
                cfg_word = $urandom;
                write_reg(ADDR_NO_REG, cfg_word);
            end
            cfg_word = $urandom;
            cfg_word[idet_pkg::SIZE_W-1:0] = idet_pkg::SIZE_W'($urandom_range(0, 7));
            write_reg(ADDR_MATRIX_SIZE, cfg_word);
            if ($urandom_range(0, 3) == 0)
                check_size_reg();
            n = active_size(size_reg);
            matrices = $urandom_range(1, 6);
            for (m = 0; m < matrices; m++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: mode = FILL_UNIFORM;
                    4, 5, 6:    mode = FILL_SMALL;
                    7, 8:       mode = FILL_EXTREME;
                    default:    mode = FILL_HADAMARD;
                endcase
                rflip = 4'($urandom);
                cflip = 4'($urandom);
                load_entries(n * n, n, mode, rflip, cflip);
            end
            // broken matrix, dropped by the next size write
            if (n > 1 && $urandom_range(0, 4) == 0)
                load_entries($urandom_range(1, n * n - 1), n, FILL_UNIFORM, 4'b0000, 4'b0000);
        end
    endtask

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("integer_matrix_determinant verification failed");
        $finish;
    end

    initial
    begin
        in_valid <= 1'b0;
        entry_value <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_size_saturation();
        test_single_entry_extremes();
        test_ignored_address();
        test_size_write_mid_load();
        test_random_matrices();
        wait_idle();
        if (errors == 0)
            $display("integer_matrix_determinant verification clean");
        else
            $display("integer_matrix_determinant verification failed");
        $finish;
    end

endmodule

// ===== integer_matrix_determinant.f =====
hw/rtl/idet_pkg.sv
hw/rtl/idet_front.sv
hw/rtl/idet_jobq.sv
hw/rtl/idet_back.sv
hw/rtl/integer_matrix_determinant.sv
dv/integer_matrix_determinant_tb.sv
